FILE: rtl/mcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

  // field widths fixed by the interface
  localparam int GV_BITS    = 16;
  localparam int LOCAL_BITS = 16;
  localparam int VLIM_BITS  = 11;
  localparam int TLIM_BITS  = 16;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  // parameter defaults
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int INDEX_BITS_DEF  = 16;

  // register reset values
  localparam logic [VLIM_BITS-1:0] VERT_LIMIT_RST = VLIM_BITS'(1000);
  localparam logic [TLIM_BITS-1:0] TRI_LIMIT_RST  = TLIM_BITS'(2000);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_VERT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRI_LIMIT  = 1'b1;

  typedef struct packed {
    logic [VLIM_BITS-1:0] vert_limit;
    logic [TLIM_BITS-1:0] tri_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0][GV_BITS-1:0] gv;
    logic                    split;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [2:0][LOCAL_BITS-1:0] local_idx;
    logic [2:0]                 new_vtx;
    logic                       chunk_end;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RD,
    ST_TBL_RD,
    ST_RESOLVE,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/mesh_chunk_splitter_core.sv
// channel  | signals                                  | direction | transfer when
// ---------+------------------------------------------+-----------+----------------------
// in       | in_valid, in_ready, global_vertex_0..2,  | input     | in_valid & in_ready
//          | surface_over_limit, last_triangle        |           |
// out      | out_valid, out_ready, local_index_0..2,  | output    | out_valid & out_ready
//          | new_vertex_0..2, chunk_end               |           |
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| input     | cfg_valid & cfg_ready
//
// a split triangle, after the input transfer, runs map read, table read, resolve/append
// for each corner through the two single-port-read memories, then a finish state closes
// the chunk and a done state hands the result to the output register; the input
// reopens once the sequencer is back in idle, and it takes no new triangle before then
// a pass-through triangle goes straight to the done state and on to the output register;
// cfg_ready is always high
// reset is synchronous: counts and handshake state clear, memories need no clearing
// one result register parts the sides: the next triangle is taken while a result
// waits, and its result holds in the sequencer until the register frees up
`timescale 1ns / 1ps
`default_nettype none

module mesh_chunk_splitter_core
  import mcs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // triangle input
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [GV_BITS-1:0]      global_vertex_0,
  input  wire logic [GV_BITS-1:0]      global_vertex_1,
  input  wire logic [GV_BITS-1:0]      global_vertex_2,
  input  wire logic                    surface_over_limit,
  input  wire logic                    last_triangle,
  // result output
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [LOCAL_BITS-1:0]   local_index_0,
  output      logic [LOCAL_BITS-1:0]   local_index_1,
  output      logic [LOCAL_BITS-1:0]   local_index_2,
  output      logic                    new_vertex_0,
  output      logic                    new_vertex_1,
  output      logic                    new_vertex_2,
  output      logic                    chunk_end,
  // register writes
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  out_res;
  logic  start;
  logic  seq_idle;
  logic  res_valid;
  logic  res_take;

  // limit registers, written any time the port offers a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vert_limit <= VERT_LIMIT_RST;
      cfg.tri_limit  <= TRI_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERT_LIMIT: cfg.vert_limit <= cfg_data[VLIM_BITS-1:0];
        REG_TRI_LIMIT:  cfg.tri_limit  <= cfg_data[TLIM_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // input side: the sequencer owns one triangle at a time
  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;

  always_comb begin
    item.gv[0] = global_vertex_0;
    item.gv[1] = global_vertex_1;
    item.gv[2] = global_vertex_2;
    item.split = surface_over_limit;
    item.last  = last_triangle;
  end

  mcs_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg),
    .res_take  (res_take),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: loads when empty or draining this cycle
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign local_index_0 = out_res.local_idx[0];
  assign local_index_1 = out_res.local_idx[1];
  assign local_index_2 = out_res.local_idx[2];
  assign new_vertex_0  = out_res.new_vtx[0];
  assign new_vertex_1  = out_res.new_vtx[1];
  assign new_vertex_2  = out_res.new_vtx[2];
  assign chunk_end     = out_res.chunk_end;

endmodule

`default_nettype wire

FILE: rtl/mcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mcs_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module mcs_seq
  import mcs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  input  wire logic  res_take,
  output      logic  idle,
  output      logic  res_valid,
  output      res_t  res
);

  localparam int KEY_BITS = (INDEX_BITS < GV_BITS) ? INDEX_BITS : GV_BITS;
  localparam int LOC_BITS = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_BITS = ((CNT_BITS > VLIM_BITS) ? CNT_BITS : VLIM_BITS) + 1;
  localparam int MAP_DEPTH = 1 << KEY_BITS;

  state_t state, state_next;

  item_t               item_q;
  logic [1:0]          corner;
  logic [CNT_BITS-1:0] vert_count;
  logic [TLIM_BITS-1:0] tri_count;
  logic [LOC_BITS-1:0] loc_cand;

  logic [KEY_BITS-1:0] key_cur;
  logic [LOC_BITS-1:0] map_rdata;
  logic [KEY_BITS-1:0] tbl_rdata;
  logic                hit;
  logic                room;
  logic                append;
  logic                close;
  logic [LIM_BITS-1:0] vlim_eff;
  logic [LIM_BITS-1:0] vc_plus3;
  logic [TLIM_BITS:0]  tri_plus2;

  assign key_cur = item_q.gv[corner][KEY_BITS-1:0];

  // reverse map: global key -> slot it was last appended to
  mcs_ram #(
    .WIDTH (LOC_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (append),
    .waddr (key_cur),
    .wdata (vert_count[LOC_BITS-1:0]),
    .raddr (key_cur),
    .rdata (map_rdata)
  );

  // chunk vertex table: slot -> global key
  mcs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (append),
    .waddr (vert_count[LOC_BITS-1:0]),
    .wdata (key_cur),
    .raddr (map_rdata),
    .rdata (tbl_rdata)
  );

  // a map entry counts only if it points inside the chunk and the slot agrees
  always_comb begin
    hit = 1'b0;
    if (CNT_BITS'(loc_cand) < vert_count) begin
      if (tbl_rdata == key_cur) begin
        hit = 1'b1;
      end
    end
  end

  assign room = (vert_count < CNT_BITS'(TABLE_DEPTH));

  always_comb begin
    vlim_eff = LIM_BITS'(cfg.vert_limit);
    if (vlim_eff > LIM_BITS'(TABLE_DEPTH)) begin
      vlim_eff = LIM_BITS'(TABLE_DEPTH);
    end
    vc_plus3  = LIM_BITS'(vert_count) + LIM_BITS'(3);
    tri_plus2 = {1'b0, tri_count} + (TLIM_BITS + 1)'(2);
    close     = (vc_plus3 >= vlim_eff) || (tri_plus2 >= {1'b0, cfg.tri_limit}) ||
                item_q.last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = item.split ? ST_MAP_RD : ST_DONE;
        end
      end
      ST_MAP_RD:  state_next = ST_TBL_RD;
      ST_TBL_RD:  state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = (corner == 2'd2) ? ST_FINISH : ST_MAP_RD;
      ST_FINISH:  state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle      = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    append    = (state == ST_RESOLVE) && !hit && room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      corner     <= 2'd0;
      vert_count <= '0;
      tri_count  <= '0;
    end else begin
      state <= state_next;
      if (start && state == ST_IDLE) begin
        corner <= 2'd0;
      end
      if (state == ST_RESOLVE) begin
        corner <= corner + 2'd1;
        if (append) begin
          vert_count <= vert_count + CNT_BITS'(1);
        end
      end
      if (state == ST_FINISH) begin
        if (close) begin
          vert_count <= '0;
          tri_count  <= '0;
        end else begin
          tri_count <= tri_count + TLIM_BITS'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start && state == ST_IDLE) begin
      item_q        <= item;
      res.local_idx <= item.gv;
      res.new_vtx   <= 3'b000;
      res.chunk_end <= 1'b0;
    end
    if (state == ST_TBL_RD) begin
      loc_cand <= map_rdata;
    end
    if (state == ST_RESOLVE) begin
      if (hit) begin
        res.local_idx[corner] <= LOCAL_BITS'(loc_cand);
        res.new_vtx[corner]   <= 1'b0;
      end else if (room) begin
        res.local_idx[corner] <= LOCAL_BITS'(vert_count);
        res.new_vtx[corner]   <= 1'b1;
      end else begin
        res.local_idx[corner] <= LOCAL_BITS'(TABLE_DEPTH - 1);
        res.new_vtx[corner]   <= 1'b0;
      end
    end
    if (state == ST_FINISH) begin
      res.chunk_end <= close;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mcs_checker
  import mcs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [LOCAL_BITS-1:0] local_index_0,
  input wire logic [LOCAL_BITS-1:0] local_index_1,
  input wire logic [LOCAL_BITS-1:0] local_index_2,
  input wire logic                  new_vertex_0,
  input wire logic                  new_vertex_1,
  input wire logic                  new_vertex_2,
  input wire logic                  chunk_end
);

  // one triangle in flight: a transfer in closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a triangle is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(local_index_0) &&
      $stable(local_index_1) && $stable(local_index_2) && $stable(chunk_end))
    else $error("stalled result changed");

  // two corners appended by one triangle go to different slots
  a_new_01_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_vertex_0 && new_vertex_1 |-> local_index_0 != local_index_1)
    else $error("corners 0 and 1 appended to the same slot");

  a_new_12_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_vertex_1 && new_vertex_2 |-> local_index_1 != local_index_2)
    else $error("corners 1 and 2 appended to the same slot");

endmodule

bind mesh_chunk_splitter_core mcs_checker u_mcs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .local_index_0 (local_index_0),
  .local_index_1 (local_index_1),
  .local_index_2 (local_index_2),
  .new_vertex_0  (new_vertex_0),
  .new_vertex_1  (new_vertex_1),
  .new_vertex_2  (new_vertex_2),
  .chunk_end     (chunk_end)
);

`default_nettype wire

FILE: tb/chunk_checker.sv
`timescale 1ns / 1ps

module chunk_checker
  import mcs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic [GV_BITS-1:0]      global_vertex_0,
  input  wire logic [GV_BITS-1:0]      global_vertex_1,
  input  wire logic [GV_BITS-1:0]      global_vertex_2,
  input  wire logic                    surface_over_limit,
  input  wire logic                    last_triangle,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic [LOCAL_BITS-1:0]   local_index_0,
  input  wire logic [LOCAL_BITS-1:0]   local_index_1,
  input  wire logic [LOCAL_BITS-1:0]   local_index_2,
  input  wire logic                    new_vertex_0,
  input  wire logic                    new_vertex_1,
  input  wire logic                    new_vertex_2,
  input  wire logic                    chunk_end,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  output int                           n_fail,
  output int                           n_pending,
  output int                           n_checked,
  output int                           n_chunks
);

  // own copy of the chunk state and the limits
  logic [GV_BITS-1:0]   chunk_verts [TABLE_DEPTH_DEF];
  int                   vert_used;
  int                   tris_in_chunk;
  logic [VLIM_BITS-1:0] vert_lim;
  logic [TLIM_BITS-1:0] tri_lim;

  res_t pending_results [$];

  function automatic res_t map_triangle(input logic [GV_BITS-1:0] g0, g1, g2,
                                        input logic split, input logic last);
    res_t               r;
    logic [GV_BITS-1:0] g [3];
    bit                 hit;
    bit                 close;
    int                 eff_lim;
    r    = '0;
    g[0] = g0;
    g[1] = g1;
    g[2] = g2;
    if (!split) begin
      for (int c = 0; c < 3; c++) r.local_idx[c] = g[c];
      return r;
    end
    for (int c = 0; c < 3; c++) begin
      hit = 1'b0;
      for (int i = 0; i < vert_used && !hit; i++) begin
        if (chunk_verts[i] == g[c]) begin
          hit            = 1'b1;
          r.local_idx[c] = LOCAL_BITS'(i);
        end
      end
      if (!hit) begin
        chunk_verts[vert_used] = g[c];
        r.local_idx[c]         = LOCAL_BITS'(vert_used);
        r.new_vtx[c]           = 1'b1;
        vert_used++;
      end
    end
    tris_in_chunk++;
    // vertex limit saturates at the table depth
    eff_lim = (int'(vert_lim) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(vert_lim);
    close   = (vert_used + 3 >= eff_lim) || (tris_in_chunk + 1 >= int'(tri_lim)) || last;
    if (close) begin
      vert_used     = 0;
      tris_in_chunk = 0;
    end
    r.chunk_end = close;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      vert_used     = 0;
      tris_in_chunk = 0;
      vert_lim      = VERT_LIMIT_RST;
      tri_lim       = TRI_LIMIT_RST;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERT_LIMIT) vert_lim = cfg_data[VLIM_BITS-1:0];
        else if (cfg_index == REG_TRI_LIMIT) tri_lim = cfg_data[TLIM_BITS-1:0];
      end
      // retire before predicting so a stray result is never matched to a fresh triangle
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no triangle waiting for it");
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          check_field("local_index_0", want.local_idx[0], local_index_0);
          check_field("local_index_1", want.local_idx[1], local_index_1);
          check_field("local_index_2", want.local_idx[2], local_index_2);
          check_field("new_vertex_0", want.new_vtx[0], new_vertex_0);
          check_field("new_vertex_1", want.new_vtx[1], new_vertex_1);
          check_field("new_vertex_2", want.new_vtx[2], new_vertex_2);
          check_field("chunk_end", want.chunk_end, chunk_end);
          n_checked++;
          if (want.chunk_end) n_chunks++;
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(map_triangle(global_vertex_0, global_vertex_1,
                                               global_vertex_2, surface_over_limit,
                                               last_triangle));
    end
    n_pending = pending_results.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mcs_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  // settle time after the last result, and before a limit change
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {RX_OPEN, RX_EVERY_THIRD, RX_RANDOM, RX_LONG_STALL} rx_mode_e;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [GV_BITS-1:0]      global_vertex_0 = '0;
  logic [GV_BITS-1:0]      global_vertex_1 = '0;
  logic [GV_BITS-1:0]      global_vertex_2 = '0;
  logic                    surface_over_limit = 1'b0;
  logic                    last_triangle = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [LOCAL_BITS-1:0]   local_index_0;
  logic [LOCAL_BITS-1:0]   local_index_1;
  logic [LOCAL_BITS-1:0]   local_index_2;
  logic                    new_vertex_0;
  logic                    new_vertex_1;
  logic                    new_vertex_2;
  logic                    chunk_end;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_chunks;

  int n_sent     = 0;
  int n_settings = 0;
  int burst_left = 0;
  int idle_count = 0;

  // receiver pattern state
  rx_mode_e rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       rx_phase = 0;
  int       rx_hold  = 0;

  always #4 clk = ~clk;

  mesh_chunk_splitter_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .global_vertex_0    (global_vertex_0),
    .global_vertex_1    (global_vertex_1),
    .global_vertex_2    (global_vertex_2),
    .surface_over_limit (surface_over_limit),
    .last_triangle      (last_triangle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .local_index_0      (local_index_0),
    .local_index_1      (local_index_1),
    .local_index_2      (local_index_2),
    .new_vertex_0       (new_vertex_0),
    .new_vertex_1       (new_vertex_1),
    .new_vertex_2       (new_vertex_2),
    .chunk_end          (chunk_end),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // predicts every result and compares it as it leaves the block
  chunk_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .global_vertex_0    (global_vertex_0),
    .global_vertex_1    (global_vertex_1),
    .global_vertex_2    (global_vertex_2),
    .surface_over_limit (surface_over_limit),
    .last_triangle      (last_triangle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .local_index_0      (local_index_0),
    .local_index_1      (local_index_1),
    .local_index_2      (local_index_2),
    .new_vertex_0       (new_vertex_0),
    .new_vertex_1       (new_vertex_1),
    .new_vertex_2       (new_vertex_2),
    .chunk_end          (chunk_end),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .n_fail             (n_fail),
    .n_pending          (n_pending),
    .n_checked          (n_checked),
    .n_chunks           (n_chunks)
  );

  // result side: the ready pattern switches to a randomly drawn mode after a random run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_EVERY_THIRD: begin
        out_ready <= (rx_phase % 3) == 0;
        rx_phase++;
      end
      RX_RANDOM: begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        // mostly ready, with the odd long stall
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 15);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("testbench failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // one triangle transfer; entered and left at a falling edge
  // valid stays high into the next triangle unless a gap is drawn
  task automatic send_tri(input logic [GV_BITS-1:0] a, b, c, input logic split, last);
    int gap;
    in_valid           <= 1'b1;
    global_vertex_0    <= a;
    global_vertex_1    <= b;
    global_vertex_2    <= c;
    surface_over_limit <= split;
    last_triangle      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      // some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // drop valid if the last burst left it high
  task automatic stop_sending();
    if (in_valid) in_valid <= 1'b0;
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    stop_sending();
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // limits only change with the block idle
  task automatic set_limits(input int vlim, input int tlim);
    drain();
    write_reg(REG_VERT_LIMIT, CFG_BITS'(vlim));
    write_reg(REG_TRI_LIMIT, CFG_BITS'(tlim));
    cfg_valid <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  // one surface: corners drawn from a small pool so vertices repeat,
  // or mostly fresh corners so the table fills toward the vertex limit
  task automatic send_surface(input int ntri, input bit split, input int pool,
                              input bit fresh, input bit mark_last);
    logic [GV_BITS-1:0] base;
    logic [GV_BITS-1:0] v [3];
    int                 seq;
    base = GV_BITS'($urandom);
    for (int t = 0; t < ntri; t++) begin
      for (int k = 0; k < 3; k++) begin
        seq = t * 3 + k;
        if (fresh && $urandom_range(0, 3) != 0) v[k] = base + GV_BITS'(seq);
        else if (fresh) v[k] = base + GV_BITS'($urandom_range(0, seq));
        else v[k] = base + GV_BITS'($urandom_range(0, pool - 1));
      end
      send_tri(v[0], v[1], v[2], split, mark_last && (t == ntri - 1));
    end
  endtask

  // random traffic under one limit setting
  task automatic run_phase(input int items, input bit fill_table);
    int stop_at;
    int pick;
    stop_at = n_sent + items;
    while (n_sent < stop_at) begin
      pick = (fill_table && $urandom_range(0, 1)) ? 5 : $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: send_surface($urandom_range(1, 20), 1'b1, $urandom_range(3, 40),
                                    1'b0, 1'b1);
        5:             send_surface($urandom_range(10, 60), 1'b1, 1, 1'b1, 1'b1);
        6:             send_surface($urandom_range(1, 10), 1'b0, 65536, 1'b0,
                                    $urandom_range(0, 1));
        7: begin
          // noise: any value in any field
          repeat ($urandom_range(1, 5))
            send_tri(GV_BITS'($urandom), GV_BITS'($urandom), GV_BITS'($urandom),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end
        8:             send_surface($urandom_range(1, 15), 1'b1, $urandom_range(3, 40),
                                    1'b0, 1'b0);
        default: begin
          // repeated corners within one triangle
          send_tri(16'd9, 16'd9, GV_BITS'($urandom_range(0, 12)), 1'b1,
                   $urandom_range(0, 1));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part under the reset limits
    // pass-through at the field extremes, last mark ignored there
    send_tri(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_tri(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 1'b0);
    // all corners equal, then two equal
    send_tri(16'd5, 16'd5, 16'd5, 1'b1, 1'b0);
    send_tri(16'd5, 16'd7, 16'd5, 1'b1, 1'b0);
    send_tri(16'h0000, 16'hFFFF, 16'd7, 1'b1, 1'b0);
    send_tri(16'hFFFF, 16'h0000, 16'd1, 1'b1, 1'b1);
    // pass-through in the middle of a chunk leaves the table alone
    send_tri(16'd10, 16'd11, 16'd12, 1'b1, 1'b0);
    send_tri(16'd10, 16'd11, 16'd12, 1'b0, 1'b0);
    send_tri(16'd12, 16'd11, 16'd13, 1'b1, 1'b1);
    // surface with no last mark: the next one carries on in the same chunk
    send_tri(16'd1, 16'd2, 16'd3, 1'b1, 1'b0);
    send_tri(16'd3, 16'd4, 16'd5, 1'b1, 1'b0);
    send_tri(16'd5, 16'd6, 16'd1, 1'b1, 1'b1);
    send_tri(16'h5555, 16'hAAAA, 16'h0001, 1'b1, 1'b1);

    // smallest limits: every split triangle closes, incl. the ones marked last
    set_limits(4, 2);
    send_tri(16'd1, 16'd2, 16'd3, 1'b1, 1'b1);
    send_tri(16'd1, 16'd1, 16'd1, 1'b1, 1'b0);
    run_phase(80, 1'b0);

    // largest limits
    set_limits(1024, 65535);
    run_phase(80, 1'b0);

    // tight limits: both closing conditions, often on the last triangle
    set_limits($urandom_range(4, 40), $urandom_range(2, 20));
    run_phase(85, 1'b0);

    // mid vertex limit reached with fresh corners
    set_limits($urandom_range(100, 300), 65535);
    run_phase(90, 1'b1);

    // anything in range
    set_limits($urandom_range(4, 1024), $urandom_range(2, 65535));
    run_phase(80, 1'b0);

    set_limits($urandom_range(8, 64), $urandom_range(2, 8));
    run_phase(85, 1'b0);

    drain();
    $display("sent %0d triangles under %0d limit settings after the reset limits",
             n_sent, n_settings);
    $display("compared %0d results, %0d of them closing a chunk", n_checked, n_chunks);
    if (n_fail == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
